### rtl/core/ilid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg: shared definitions for the indexed list
// Operation codes, index widths and the command structs broadcast from the
// control logic to the row of entry cells.
// ----------------------------------------------------------------------------
package ilid_pkg;

   // default and largest supported list capacity
   localparam int CAPACITY_DEFAULT = 64;
   localparam int CAPACITY_MAX     = 1024;

   // widths of the request and response fields
   localparam int OP_W   = 3;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;

   // index width wide enough for any length up to the largest capacity
   localparam int IDX_W = $clog2(CAPACITY_MAX + 1);

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_READ   = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   // update command seen by every cell, already qualified by accept and error
   typedef struct packed {
      logic              do_append;
      logic              do_write;
      logic              do_delete;
      logic              do_insert;
      logic              do_clear;
      logic [IDX_W-1:0]  pos;
      logic [IDX_W-1:0]  count;
      logic [DATA_W-1:0] value;
   } ilid_cmd_type;

   // read select seen by every cell while a read result is collected
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] pos;
   } ilid_rd_type;

endpackage

### rtl/core/ilid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_cell: one entry of the list
// Holds a single value and on each command either keeps it, loads the request
// value, takes a neighbor's value (shift up or down) or clears to zero.
// ----------------------------------------------------------------------------
module ilid_cell #(
   parameter int INDEX = 0
) (
   input  logic                         clock,
   input  ilid_pkg::ilid_cmd_type       cmd,
   input  ilid_pkg::ilid_rd_type        rd_sel,
   input  logic [ilid_pkg::DATA_W-1:0]  left_in,
   input  logic [ilid_pkg::DATA_W-1:0]  right_in,
   output logic [ilid_pkg::DATA_W-1:0]  entry_out,
   output logic [ilid_pkg::DATA_W-1:0]  leaf_out
);

   localparam logic [ilid_pkg::IDX_W-1:0] MY_IDX = ilid_pkg::IDX_W'(INDEX);

   logic [ilid_pkg::DATA_W-1:0] entry_ff;
   logic [ilid_pkg::DATA_W-1:0] entry_in;

   // next entry value
   always_comb begin
      entry_in = entry_ff;
      if (cmd.do_clear) begin
         entry_in = '0;
      end else if (cmd.do_append && (MY_IDX == cmd.count)) begin
         entry_in = cmd.value;
      end else if (cmd.do_write && (MY_IDX == cmd.pos)) begin
         entry_in = cmd.value;
      end else if (cmd.do_delete && (MY_IDX >= cmd.pos)) begin
         entry_in = right_in;
      end else if (cmd.do_insert && (MY_IDX > cmd.pos)) begin
         entry_in = left_in;
      end else if (cmd.do_insert && (MY_IDX == cmd.pos)) begin
         entry_in = cmd.value;
      end
   end

   // entry storage, undefined until written
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

   // contribute own value to the read tree only when selected
   assign leaf_out = (rd_sel.en && (MY_IDX == rd_sel.pos)) ? entry_ff : '0;

endmodule

### rtl/core/ilid_or_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_or_tree: registered OR reduction of the cell read taps
// At most one leaf is nonzero; each tree level is a register stage.
// ----------------------------------------------------------------------------
module ilid_or_tree #(
   parameter int CAPACITY = ilid_pkg::CAPACITY_DEFAULT
) (
   input  logic                         clock,
   input  logic [ilid_pkg::DATA_W-1:0]  leaf_in [CAPACITY],
   output logic [ilid_pkg::DATA_W-1:0]  root_out
);

   localparam int LEVELS = $clog2(CAPACITY);
   localparam int LEAVES = 1 << LEVELS;

   // heap layout: node 1 is the root, node k has children 2k and 2k+1
   logic [ilid_pkg::DATA_W-1:0] node_ff [1:LEAVES-1];

   for (genvar k = 1; k < LEAVES; k++) begin : g_node
      if (2 * k >= LEAVES) begin : g_bottom
         // children are leaves; pad beyond the capacity with zero
         localparam int LO = 2 * k - LEAVES;
         if (LO + 1 < CAPACITY) begin : g_two
            always_ff @(posedge clock) begin
               node_ff[k] <= leaf_in[LO] | leaf_in[LO+1];
            end
         end else if (LO < CAPACITY) begin : g_one
            always_ff @(posedge clock) begin
               node_ff[k] <= leaf_in[LO];
            end
         end else begin : g_none
            always_ff @(posedge clock) begin
               node_ff[k] <= '0;
            end
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            node_ff[k] <= node_ff[2*k] | node_ff[2*k+1];
         end
      end
   end

   assign root_out = node_ff[1];

endmodule

### rtl/core/indexed_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: ordered list with indexed insert and delete
// A row of entry cells shifts the entries from the position onward for insert
// and delete; read data is collected through a registered OR tree.
// ----------------------------------------------------------------------------
// response: after accept, the control waits out the read OR tree depth
// items: one item at a time; a new request is stalled until the response
//        is taken
// reset: length and control clear; entry values are not cleared
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
   parameter int CAPACITY = ilid_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [ilid_pkg::OP_W-1:0]    req_op,
   input  logic        [ilid_pkg::POS_W-1:0]   req_position,
   input  logic signed [ilid_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ilid_pkg::DATA_W-1:0]  rsp_read_value,
   output logic                                rsp_error,
   output logic        [ilid_pkg::POS_W-1:0]   rsp_length
);

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int LEVELS = $clog2(CAPACITY);
   localparam int WAIT_W = $clog2(LEVELS + 1);
   localparam logic [ilid_pkg::IDX_W-1:0] CAP_EXT = ilid_pkg::IDX_W'(CAPACITY);

   // control states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WAIT = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                   state_ff;
   logic [1:0]                   state_in;
   logic [WAIT_W-1:0]            wait_ff;
   logic [WAIT_W-1:0]            wait_in;
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic                         error_ff;
   logic                         error_in;
   logic [ilid_pkg::POS_W-1:0]   length_ff;
   ilid_pkg::ilid_rd_type        rd_ff;
   ilid_pkg::ilid_rd_type        rd_in;

   logic                         req_acc;
   logic                         rsp_acc;
   logic [ilid_pkg::IDX_W-1:0]   pos_ext;
   logic [ilid_pkg::IDX_W-1:0]   cnt_ext;
   logic [ilid_pkg::IDX_W-1:0]   cnt_next_ext;
   logic                         full;
   logic                         idx_bad;
   ilid_pkg::ilid_cmd_type       cmd;

   logic [ilid_pkg::DATA_W-1:0]  entry [CAPACITY];
   logic [ilid_pkg::DATA_W-1:0]  leaf [CAPACITY];
   logic [ilid_pkg::DATA_W-1:0]  root;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   assign pos_ext = ilid_pkg::IDX_W'(req_position);
   assign cnt_ext = ilid_pkg::IDX_W'(count_ff);
   assign full    = (cnt_ext == CAP_EXT);
   assign idx_bad = (pos_ext >= cnt_ext);

   // decode, range checks and new length
   always_comb begin
      cmd          = '0;
      cmd.pos      = pos_ext;
      cmd.count    = cnt_ext;
      cmd.value    = req_value;
      error_in     = 1'b0;
      count_in     = count_ff;
      rd_in.en     = 1'b0;
      rd_in.pos    = pos_ext;
      case (req_op)
         ilid_pkg::OP_APPEND: begin
            error_in      = full;
            cmd.do_append = req_acc && !full;
            if (!full) count_in = count_ff + CW'(1);
         end
         ilid_pkg::OP_READ: begin
            error_in = idx_bad;
            rd_in.en = !idx_bad;
         end
         ilid_pkg::OP_WRITE: begin
            error_in     = idx_bad;
            cmd.do_write = req_acc && !idx_bad;
         end
         ilid_pkg::OP_DELETE: begin
            error_in      = idx_bad;
            cmd.do_delete = req_acc && !idx_bad;
            if (!idx_bad) count_in = count_ff - CW'(1);
         end
         ilid_pkg::OP_INSERT: begin
            error_in      = idx_bad || full;
            cmd.do_insert = req_acc && !idx_bad && !full;
            if (!idx_bad && !full) count_in = count_ff + CW'(1);
         end
         ilid_pkg::OP_CLEAR: begin
            error_in     = (pos_ext > CAP_EXT);
            cmd.do_clear = req_acc && !(pos_ext > CAP_EXT);
            if (!(pos_ext > CAP_EXT)) count_in = CW'(pos_ext);
         end
         default: begin
            error_in = 1'b1;
         end
      endcase
   end

   assign cnt_next_ext = ilid_pkg::IDX_W'(count_in);

   // control sequencing: accept, wait for the read tree, hold the response
   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_WAIT;
               wait_in  = WAIT_W'(LEVELS - 1);
            end
         end
         ST_WAIT: begin
            if (wait_ff == '0) state_in = ST_DONE;
            else wait_in = wait_ff - WAIT_W'(1);
         end
         ST_DONE: begin
            if (rsp_acc) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= '0;
         count_ff <= '0;
         rd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         if (req_acc) begin
            count_ff <= count_in;
            rd_ff    <= rd_in;
         end
      end
   end

   // response fields captured with the item
   always_ff @(posedge clock) begin
      if (req_acc) begin
         error_ff  <= error_in;
         length_ff <= cnt_next_ext[ilid_pkg::POS_W-1:0];
      end
   end

   // row of entry cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ilid_pkg::DATA_W-1:0] left_d;
      logic [ilid_pkg::DATA_W-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_left
         assign left_d = entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_right
         assign right_d = entry[i+1];
      end
      ilid_cell #(
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .rd_sel    (rd_ff),
         .left_in   (left_d),
         .right_in  (right_d),
         .entry_out (entry[i]),
         .leaf_out  (leaf[i])
      );
   end

   // read data collection
   ilid_or_tree #(
      .CAPACITY (CAPACITY)
   ) u_tree (
      .clock    (clock),
      .leaf_in  (leaf),
      .root_out (root)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_read_value = root;
   assign rsp_error      = error_ff;
   assign rsp_length     = length_ff;

   // length never exceeds the capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      ilid_pkg::IDX_W'(count_ff) <= CAP_EXT)
      else $error("list length beyond capacity");

   // a rejected item leaves the length alone
   a_err_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (req_acc && error_in) |=> $stable(count_ff))
      else $error("rejected item changed the length");

   // an error response carries zero read data
   a_err_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_read_value == '0))
      else $error("error response with nonzero read data");

   // an accepted item blocks further items until its response
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (req_stall && !rsp_valid))
      else $error("accepted item did not enter the wait state");

   // a response is only dropped after it is taken
   a_rsp_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule
